// ===== hdl/gds_pkg.sv =====
// gds_pkg: types and constants shared by the dispense sequencer, its channel
// interfaces and its port checker. No dependencies.
`timescale 1ns / 1ps

package gds_pkg;

  // field widths fixed by the item formats
  localparam int unsigned OpW     = 3;
  localparam int unsigned TargetW = 23;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned SpeedW  = 15;
  localparam int unsigned RemW    = 26;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned SpdRegW = 14;
  localparam int unsigned TickW   = 11;

  localparam logic [SpdRegW-1:0] SpeedMax   = 14'd10000;
  localparam logic [TickW-1:0]   TickSatMax = 11'd2047;
  localparam logic [15:0]        SettleMax  = 16'd65535;

  // weight thresholds in centigrams
  localparam int unsigned FastNearCg   = 200;
  localparam int unsigned ApprNearCg   = 20;
  localparam int unsigned SettleDoneCg = 1;

  // result saturation bounds
  localparam logic signed [RemW-1:0] RemMax = 26'sh1FFFFFF;
  localparam logic signed [RemW-1:0] RemMin = 26'sh2000000;

  typedef enum logic [ModeW-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_FAST     = 3'd1,
    MODE_APPROACH = 3'd2,
    MODE_TRICKLE  = 3'd3,
    MODE_SETTLE   = 3'd4,
    MODE_SUCK     = 3'd5,
    MODE_ERROR    = 3'd6
  } mode_e;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 3'd0,
    OP_WEIGHT = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_STEP   = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAST_SPEED      = 3'd0,
    CFG_APPROACH_SPEED  = 3'd1,
    CFG_TRICKLE_SPEED   = 3'd2,
    CFG_SUCK_BACK_STEPS = 3'd3,
    CFG_SUCK_BACK_SPEED = 3'd4,
    CFG_STOP_OFFSET     = 3'd5,
    CFG_SETTLE_TIME     = 3'd6,
    CFG_SCALE_TIMEOUT   = 3'd7
  } cfg_e;

endpackage

// ===== hdl/gds_in_if.sv =====
// gds_in_if: event request channel of the dispense sequencer
// depends on gds_pkg for the fixed field widths
`timescale 1ns / 1ps

interface gds_in_if
  import gds_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [OpW-1:0]                operation;
  logic signed [WEIGHT_BITS-1:0] weight;
  logic [TargetW-1:0]            target;

  modport source (output valid, output operation, output weight, output target,
                  input ready);
  modport sink   (input valid, input operation, input weight, input target,
                  output ready);
endinterface

// ===== hdl/gds_out_if.sv =====
// gds_out_if: result request channel of the dispense sequencer
// depends on gds_pkg for the fixed field widths
`timescale 1ns / 1ps

interface gds_out_if
  import gds_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ModeW-1:0]         mode;
  logic                     motor_enable;
  logic signed [SpeedW-1:0] motor_speed;
  logic signed [RemW-1:0]   remaining;

  modport source (output valid, output mode, output motor_enable, output motor_speed,
                  output remaining, input ready);
  modport sink   (input valid, input mode, input motor_enable, input motor_speed,
                  input remaining, output ready);
endinterface

// ===== hdl/gravimetric_dispense_sequencer_unit.sv =====
// gravimetric_dispense_sequencer_unit: weight-driven pump dispense sequencer
// depends on gds_pkg, gds_in_if and gds_out_if
`timescale 1ns / 1ps

// Takes one event request per cycle unless back-pressured (tick, scale reading, start,
// stop, step done) and returns exactly one result request per event: mode, motor
// enable, signed motor speed and saturated remaining weight in centigrams. An event
// passes through two registers: the input register, then the state and result
// register, so a result is presented once its event has passed both registers, and a
// new event can be taken every cycle unless back-pressured. The state update of one
// event (weight capture, stale-scale check, remaining = target - (latest - start),
// one mode transition) is done combinationally between those registers, which is
// what lets the next event follow at once. The result register holds a result until
// it is taken while the input register already catches the next event;
// back-pressure reaches the input only when both are full. Configuration writes are
// meant to be done while no event is in flight.
module gravimetric_dispense_sequencer_unit
  import gds_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  gds_in_if.sink             in_i,
  gds_out_if.source          out_o
);

  // working width for remaining: covers target, weight difference and x100
  localparam int unsigned RW = WEIGHT_BITS + 10;
  localparam int unsigned XW = RW + 7;

  // configuration registers
  logic [SpdRegW-1:0] fast_speed_q, approach_speed_q, trickle_speed_q, suck_speed_q;
  logic [15:0]        suck_steps_q, stop_offset_q, settle_time_q;
  logic [TickW-1:0]   scale_timeout_q;

  // input register
  logic                          in_vld_q;
  logic [OpW-1:0]                op_q;
  logic signed [WEIGHT_BITS-1:0] weight_q;
  logic [TargetW-1:0]            target_q;

  // sequencer state
  mode_e                         mode_q, mode_d;
  logic                          enable_q, enable_d;
  logic signed [WEIGHT_BITS-1:0] latest_q, latest_d;
  logic signed [WEIGHT_BITS-1:0] start_q, start_d;
  logic [TargetW-1:0]            tgt_q, tgt_d;
  logic [TickW-1:0]              ticks_q, ticks_d;
  logic [15:0]                   settle_q, settle_d;
  logic [15:0]                   steps_q, steps_d;

  // result register
  logic                     out_vld_q;
  mode_e                    res_mode_q;
  logic                     res_en_q;
  logic signed [SpeedW-1:0] res_speed_q, speed_d;
  logic signed [RemW-1:0]   res_rem_q, rem_sat_d;

  logic                     adv;
  logic                     in_rdy;
  mode_e                    mode_ev;     // mode after the event and timeout check
  logic signed [RW-1:0]     rem;
  logic signed [RW-1:0]     tgt_ext;
  logic signed [XW-1:0]     rem_x, tgt_x, rem10, rem100;

  // handshake: the result register frees when empty or taken
  assign adv    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_rdy = !in_vld_q || !out_vld_q || out_o.ready;
  assign in_i.ready = in_rdy;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_speed_q     <= 14'd10000;
      approach_speed_q <= 14'd2000;
      trickle_speed_q  <= 14'd1000;
      suck_steps_q     <= 16'd250;
      suck_speed_q     <= 14'd800;
      stop_offset_q    <= 16'd10;
      settle_time_q    <= 16'd500;
      scale_timeout_q  <= 11'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_FAST_SPEED:      fast_speed_q     <= cfg_data_i[SpdRegW-1:0];
        CFG_APPROACH_SPEED:  approach_speed_q <= cfg_data_i[SpdRegW-1:0];
        CFG_TRICKLE_SPEED:   trickle_speed_q  <= cfg_data_i[SpdRegW-1:0];
        CFG_SUCK_BACK_STEPS: suck_steps_q     <= cfg_data_i;
        CFG_SUCK_BACK_SPEED: suck_speed_q     <= cfg_data_i[SpdRegW-1:0];
        CFG_STOP_OFFSET:     stop_offset_q    <= cfg_data_i;
        CFG_SETTLE_TIME:     settle_time_q    <= cfg_data_i;
        CFG_SCALE_TIMEOUT:   scale_timeout_q  <= cfg_data_i[TickW-1:0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      op_q     <= in_i.operation;
      weight_q <= in_i.weight;
      target_q <= in_i.target;
    end
  end

  // event application, stale-scale check, remaining and one transition
  always_comb begin
    mode_ev  = mode_q;
    enable_d = enable_q;
    latest_d = latest_q;
    start_d  = start_q;
    tgt_d    = tgt_q;
    ticks_d  = ticks_q;
    settle_d = settle_q;
    steps_d  = steps_q;

    unique case (op_q)
      OP_TICK: begin
        if (ticks_q != TickSatMax) ticks_d = ticks_q + 1'b1;
        if (settle_q != SettleMax) settle_d = settle_q + 1'b1;
      end
      OP_WEIGHT: begin
        latest_d = weight_q;
        ticks_d  = '0;
      end
      OP_START: begin
        // zero target means no start
        if (target_q != '0) begin
          enable_d = 1'b1;
          tgt_d    = target_q;
          start_d  = latest_q;
          ticks_d  = '0;
          mode_ev  = MODE_FAST;
        end
      end
      OP_STOP: begin
        enable_d = 1'b0;
        mode_ev  = MODE_IDLE;
      end
      OP_STEP: begin
        if (mode_q == MODE_SUCK && steps_q != '0) steps_d = steps_q - 1'b1;
      end
      default: ;
    endcase

    // stale scale while the pump is moving
    if ((mode_ev == MODE_FAST || mode_ev == MODE_APPROACH ||
         mode_ev == MODE_TRICKLE || mode_ev == MODE_SUCK) &&
        (ticks_d > scale_timeout_q)) begin
      enable_d = 1'b0;
      mode_ev  = MODE_ERROR;
    end

    // remaining = target - (latest - start), full precision
    tgt_ext = $signed({{(RW-TargetW){1'b0}}, tgt_d});
    rem     = tgt_ext - ($signed({{(RW-WEIGHT_BITS){latest_d[WEIGHT_BITS-1]}}, latest_d}) -
                         $signed({{(RW-WEIGHT_BITS){start_d[WEIGHT_BITS-1]}}, start_d}));
    rem_x   = $signed({{(XW-RW){rem[RW-1]}}, rem});
    tgt_x   = $signed({{(XW-TargetW){1'b0}}, tgt_d});
    rem10   = (rem_x <<< 3) + (rem_x <<< 1);
    rem100  = (rem_x <<< 6) + (rem_x <<< 5) + (rem_x <<< 2);

    mode_d = mode_ev;
    case (mode_ev)
      MODE_FAST: begin
        // within 10 percent of target or 2 g
        if (rem10 <= tgt_x || rem <= $signed(RW'(FastNearCg))) mode_d = MODE_APPROACH;
      end
      MODE_APPROACH: begin
        // within 1 percent of target or 0.2 g
        if (rem100 <= tgt_x || rem <= $signed(RW'(ApprNearCg))) mode_d = MODE_TRICKLE;
      end
      MODE_TRICKLE: begin
        if (rem <= $signed({{(RW-16){1'b0}}, stop_offset_q})) begin
          settle_d = '0;
          mode_d   = MODE_SETTLE;
        end
      end
      MODE_SETTLE: begin
        if (settle_d >= settle_time_q) begin
          if (rem > $signed(RW'(SettleDoneCg))) begin
            mode_d = MODE_TRICKLE;
          end else begin
            steps_d = suck_steps_q;
            mode_d  = MODE_SUCK;
          end
        end
      end
      MODE_SUCK: begin
        if (steps_d == '0) mode_d = MODE_IDLE;
      end
      default: ;
    endcase

    // speed by mode, register values clamped to the maximum
    case (mode_d)
      MODE_FAST:
        speed_d = $signed({1'b0, (fast_speed_q > SpeedMax) ? SpeedMax : fast_speed_q});
      MODE_APPROACH:
        speed_d = $signed({1'b0, (approach_speed_q > SpeedMax) ? SpeedMax : approach_speed_q});
      MODE_TRICKLE:
        speed_d = $signed({1'b0, (trickle_speed_q > SpeedMax) ? SpeedMax : trickle_speed_q});
      MODE_SUCK:
        speed_d = -$signed({1'b0, (suck_speed_q > SpeedMax) ? SpeedMax : suck_speed_q});
      default:
        speed_d = '0;
    endcase

    // saturate remaining to the result width
    if (rem > $signed({{(RW-RemW){RemMax[RemW-1]}}, RemMax})) begin
      rem_sat_d = RemMax;
    end else if (rem < $signed({{(RW-RemW){RemMin[RemW-1]}}, RemMin})) begin
      rem_sat_d = RemMin;
    end else begin
      rem_sat_d = rem[RemW-1:0];
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      enable_q    <= 1'b1;
      latest_q    <= '0;
      start_q     <= '0;
      tgt_q       <= '0;
      ticks_q     <= '0;
      settle_q    <= '0;
      steps_q     <= '0;
      out_vld_q   <= 1'b0;
      res_mode_q  <= MODE_IDLE;
      res_en_q    <= 1'b0;
      res_speed_q <= '0;
      res_rem_q   <= '0;
    end else begin
      if (adv) begin
        mode_q      <= mode_d;
        enable_q    <= enable_d;
        latest_q    <= latest_d;
        start_q     <= start_d;
        tgt_q       <= tgt_d;
        ticks_q     <= ticks_d;
        settle_q    <= settle_d;
        steps_q     <= steps_d;
        out_vld_q   <= 1'b1;
        res_mode_q  <= mode_d;
        res_en_q    <= enable_d;
        res_speed_q <= speed_d;
        res_rem_q   <= rem_sat_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.mode         = res_mode_q;
  assign out_o.motor_enable = res_en_q;
  assign out_o.motor_speed  = res_speed_q;
  assign out_o.remaining    = res_rem_q;

endmodule

// ===== hdl/gds_checker.sv =====
// gds_checker: port-level checks on the dispense sequencer result channel
// depends on gds_pkg; bound to gravimetric_dispense_sequencer_unit below
`timescale 1ns / 1ps

module gds_checker
  import gds_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ModeW-1:0]         out_mode,
  input logic                     out_enable,
  input logic signed [SpeedW-1:0] out_speed,
  input logic signed [RemW-1:0]   out_remaining
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_mode) &&
                                $stable(out_speed) && $stable(out_remaining))
    else $error("result changed while stalled");

  // motor at rest when idle, settling or in error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_mode == MODE_IDLE || out_mode == MODE_SETTLE ||
                  out_mode == MODE_ERROR) |-> out_speed == '0)
    else $error("nonzero speed in a resting mode");

  // error always comes with the driver disabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_mode == MODE_ERROR |-> !out_enable)
    else $error("driver enabled in error");

  // suck back only ever reverses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_mode == MODE_SUCK |-> out_speed[SpeedW-1] || out_speed == '0)
    else $error("forward speed during suck back");

  // forward modes never reverse and stay within the speed limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_mode == MODE_FAST || out_mode == MODE_APPROACH ||
                  out_mode == MODE_TRICKLE)
    |-> !out_speed[SpeedW-1] && out_speed <= $signed({1'b0, SpeedMax}))
    else $error("forward speed out of range");

endmodule

bind gravimetric_dispense_sequencer_unit gds_checker u_gds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_vld_q),
  .out_ready     (out_o.ready),
  .out_mode      (res_mode_q),
  .out_enable    (res_en_q),
  .out_speed     (res_speed_q),
  .out_remaining (res_rem_q)
);
